>>> design/hcbp_pkg.sv
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared types and constants for the Huffman code bit packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

  // Request commands
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_ENCODE = 2'd1;
  localparam logic [1:0] CMD_FLUSH  = 2'd2;

  localparam int BYTE_BITS = 8;
  localparam int CODE_W    = 32;
  localparam int LEN_W     = 6;
  localparam int SYM_W     = 8;
  localparam int PEND_W    = 7;
  localparam int CNT_W     = 3;
  // left-aligned work word: up to 7 pending bits plus a 32-bit code
  localparam int WORD_W    = 40;

  // Controller to datapath commands
  typedef struct packed {
    logic mem_write;   // store a code table entry
    logic mem_read;    // read the entry of the incoming symbol
    logic build;       // merge pending bits and code into the work word
    logic flush_load;  // move padded pending bits into the work word
    logic emit;        // load the next byte into the output register
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic build_empty; // merged bits form no full byte
    logic pend_empty;  // no bits pending
    logic last;        // one byte left in the work word
    logic out_free;    // output register can take a byte
  } dp_stat_t;

endpackage

>>> design/hcbp_ctrl.sv
// ----------------------------------------------------------------------------
// hcbp_ctrl
// Sequencer: accepts requests, steps build and byte emission.
// ----------------------------------------------------------------------------
module hcbp_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [1:0]            in_cmd,
  input  hcbp_pkg::dp_stat_t    stat,
  output hcbp_pkg::ctrl_cmd_t   cmd,
  output logic                  in_stall
);
  import hcbp_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BUILD,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);

  // Commands and next state
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            CMD_LOAD: cmd.mem_write = 1'b1;
            CMD_ENCODE: begin
              cmd.mem_read = 1'b1;
              state_nxt    = S_BUILD;
            end
            CMD_FLUSH: begin
              cmd.flush_load = 1'b1;
              if (!stat.pend_empty) state_nxt = S_EMIT;
            end
            default: ;  // unused code: dropped
          endcase
        end
      end
      S_BUILD: begin
        cmd.build = 1'b1;
        state_nxt = stat.build_empty ? S_IDLE : S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = stat.out_free;
        if (stat.out_free && stat.last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> design/hcbp_dp.sv
// ----------------------------------------------------------------------------
// hcbp_dp
// Code table, bit accumulator, work word and output register.
// ----------------------------------------------------------------------------
module hcbp_dp #(
  parameter int MAX_CODE_LEN = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  hcbp_pkg::ctrl_cmd_t                   cmd,
  output hcbp_pkg::dp_stat_t                    stat,
  input  logic [hcbp_pkg::SYM_W-1:0]            in_symbol,
  input  logic [hcbp_pkg::CODE_W-1:0]           in_code_value,
  input  logic [hcbp_pkg::LEN_W-1:0]            in_code_length,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [hcbp_pkg::BYTE_BITS-1:0]        out_byte,
  output logic                                  out_last
);
  import hcbp_pkg::*;

  localparam int LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam logic [LEN_W-1:0] LEN_CAP_V = LEN_W'(LEN_CAP);
  localparam int ENTRY_W = LEN_W + CODE_W;

  // Code table: {length, code}
  logic [ENTRY_W-1:0] code_mem [256];
  logic [ENTRY_W-1:0] rd_data_r;

  logic [PEND_W-1:0]    pending_r, pending_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [WORD_W-1:0]    word_r, word_nxt;
  logic [CNT_W-1:0]     nb_r, nb_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [BYTE_BITS-1:0] out_byte_r;
  logic                 out_last_r;

  logic [LEN_W-1:0]  len_raw, eff_len, total;
  logic [CODE_W-1:0] code_left;
  logic [PEND_W-1:0] pend_left, tail_pick, tail;
  logic [WORD_W-1:0] word_build;
  logic [CNT_W-1:0]  build_nb, build_rem;

  always_ff @(posedge clk) begin
    if (cmd.mem_write) code_mem[in_symbol] <= {in_code_length, in_code_value};
    if (cmd.mem_read)  rd_data_r <= code_mem[in_symbol];
  end

  // Merge pending bits and the looked-up code, both left-aligned
  always_comb begin
    len_raw    = rd_data_r[ENTRY_W-1 -: LEN_W];
    eff_len    = (len_raw > LEN_CAP_V) ? LEN_CAP_V : len_raw;
    code_left  = rd_data_r[CODE_W-1:0] << (LEN_W'(CODE_W) - eff_len);
    pend_left  = pending_r << (CNT_W'(PEND_W) - cnt_r);
    word_build = {pend_left, {(WORD_W-PEND_W){1'b0}}}
               | ({code_left, {BYTE_BITS{1'b0}}} >> cnt_r);
    total      = LEN_W'(cnt_r) + eff_len;
    build_nb   = total[LEN_W-1:3];
    build_rem  = total[2:0];
    unique case (build_nb)
      3'd0:    tail_pick = word_build[39:33];
      3'd1:    tail_pick = word_build[31:25];
      3'd2:    tail_pick = word_build[23:17];
      3'd3:    tail_pick = word_build[15:9];
      default: tail_pick = word_build[7:1];
    endcase
    tail = tail_pick >> (CNT_W'(PEND_W) - build_rem);
  end

  assign stat.build_empty = (build_nb == '0);
  assign stat.pend_empty  = (cnt_r == '0);
  assign stat.last        = (nb_r == CNT_W'(1));
  assign stat.out_free    = !out_valid_r || !out_stall;

  // Accumulator, work word and output register updates
  always_comb begin
    pending_nxt   = pending_r;
    cnt_nxt       = cnt_r;
    word_nxt      = word_r;
    nb_nxt        = nb_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.build) begin
      word_nxt    = word_build;
      nb_nxt      = build_nb;
      pending_nxt = tail;
      cnt_nxt     = build_rem;
    end
    if (cmd.flush_load) begin
      word_nxt    = {pend_left, 1'b0, {(WORD_W-BYTE_BITS){1'b0}}};
      nb_nxt      = CNT_W'(1);
      pending_nxt = '0;
      cnt_nxt     = '0;
    end
    if (cmd.emit) begin
      word_nxt      = word_r << BYTE_BITS;
      nb_nxt        = nb_r - CNT_W'(1);
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pending_r   <= pending_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    nb_r   <= nb_nxt;
    if (cmd.emit) begin
      out_byte_r <= word_r[WORD_W-1 -: BYTE_BITS];
      out_last_r <= (nb_r == CNT_W'(1));
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

>>> design/huffman_code_bit_packer.sv
// ----------------------------------------------------------------------------
// huffman_code_bit_packer
// Loads a 256-entry code table and packs variable-length codes into bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests (in_valid/in_stall) carry in_cmd: load writes the table
//   entry at in_symbol; encode appends the code of in_symbol, first bit
//   first; flush pads pending bits with zeros and sends that byte.
//   Result requests (out_valid/out_stall) carry one packed byte each,
//   earliest bit in bit 7; out_last marks the final byte of a request.
// Timing:
//   load writes the table entry. encode steps through the table read, the merge
//   and one emit step per byte formed, 0 to 4. flush loads the padded bits, then emits their byte if any were pending.
//   The single output register drains one byte per cycle while the receiver
//   does not stall and sets the encode rate; the table read adds a step to each encode.
//   A new request is taken while the last byte still waits in the output
//   register. When the receiver stalls, bytes hold and input stalls while bytes are emitted.
// Reset:
//   Clears pending bits and the output valid flag; the code table is not
//   cleared and must be loaded before its symbols are encoded.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer #(
  parameter int MAX_CODE_LEN = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_cmd,
  input  logic [hcbp_pkg::SYM_W-1:0]      in_symbol,
  input  logic [hcbp_pkg::CODE_W-1:0]     in_code_value,
  input  logic [hcbp_pkg::LEN_W-1:0]      in_code_length,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [hcbp_pkg::BYTE_BITS-1:0]  out_byte,
  output logic                            out_last
);
  import hcbp_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  hcbp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .stat     (stat),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  hcbp_dp #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_symbol      (in_symbol),
    .in_code_value  (in_code_value),
    .in_code_length (in_code_length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_last       (out_last)
  );

  // An accepted encode holds off the next request while it is merged
  a_encode_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_cmd == CMD_ENCODE) |=> in_stall)
    else $error("encode request not followed by busy");

  // A table load never produces a byte
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_cmd == CMD_LOAD && !out_valid) |=> !out_valid)
    else $error("table load produced output");

  // At most one datapath command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("conflicting datapath commands");

endmodule
